FILE: design/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg: shared types, constants and helpers for the waypoint mover
// Fixed-point format, store geometry, command and register codes, and the
// saturating helpers used throughout the datapath.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_WP    = 16;
  localparam int IDX_W     = $clog2(MAX_WP);
  localparam int CNT_W     = $clog2(MAX_WP + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 * MAX_WP;
  localparam int TOT_W     = 32 + CNT_W;

  // Coincidence threshold: round(0.00001 * 2^FRAC_BITS), at least one raw step.
  localparam longint EPS_CALC = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [31:0] EPS_RAW = 32'((EPS_CALC > 0) ? EPS_CALC : 1);
  localparam logic [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);

  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_ACCEL_RATE  = 2'd1;
  localparam logic [1:0] REG_DECEL_RATE  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_APPEND  = 2'd2
  } cmd_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RP_RD, ST_RP_DAT, ST_RP_LEN,
    ST_SL_DIFF, ST_SL_M0, ST_SL_M1, ST_SL_M2, ST_SL_M3, ST_SL_SQ,
    ST_PK_M0, ST_PK_M1, ST_PK_M2, ST_PK_DF, ST_PK_M3, ST_PK_M4, ST_PK_Y, ST_PK_SQ,
    ST_PK_VM, ST_PK_D0, ST_PK_DA, ST_PK_DD, ST_PK_CR, ST_PK_D1, ST_PK_D2,
    ST_TK_A, ST_TK_B, ST_TK_C, ST_TK_D, ST_TK_E, ST_TK_F, ST_TK_G, ST_TK_H,
    ST_TK_I, ST_TK_J,
    ST_WK_RD, ST_WK_DAT, ST_WK_LEN,
    ST_IP_MUL, ST_IP_DIV, ST_IP_WAIT, ST_IP_WR,
    ST_TK_END, ST_FIN
  } state_t;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // Product of two Q values back to Q, saturated.
  function automatic logic [31:0] qmul(input logic [63:0] p);
    return sat32(p >> FRAC_BITS);
  endfunction

  function automatic logic [63:0] frac_shl(input logic [31:0] x);
    return {32'd0, x} << FRAC_BITS;
  endfunction

  function automatic logic [31:0] min32(input logic [31:0] x, input logic [31:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [31:0] clamp_s32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

FILE: design/trapezoidal_waypoint_mover.sv
// ----------------------------------------------------------------------------
// trapezoidal_waypoint_mover: waypoint follower with trapezoidal speed profile
// Holds a queue of 3D waypoints in a two-bank memory, replans on each replace
// or append command and evaluates constant-acceleration motion on each tick.
// ----------------------------------------------------------------------------
// One word in gives one word out. A tick on a stopped mover or an unused
// command goes straight to the output stage. A live tick runs the
// kinematics, then steps past every waypoint passed, then interpolates on
// the current segment. A replace or append measures each stored waypoint,
// then plans the peak speed and phase times. The run time is set by the
// shared divider and the shared square-root unit, each one result bit per
// cycle, and by the single read port of the waypoint memory. A finished
// word waits in the output register while the next word is taken in. The
// block needs no clearing pass after reset.
module trapezoidal_waypoint_mover (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // now_time, point_x, point_y, point_z
  input  logic [1:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // pos_x, pos_y, pos_z, speed, moving,
                                  // waypoints_left, path_full, zero pad
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IDX_W  = twm_pkg::IDX_W;
  localparam int CNT_W  = twm_pkg::CNT_W;
  localparam int ADDR_W = twm_pkg::ADDR_W;
  localparam int TOT_W  = twm_pkg::TOT_W;

  twm_pkg::state_t state, state_next;
  twm_pkg::cmd_t   in_cmd;

  logic [31:0] speed_limit, accel_rate, decel_rate;
  logic [31:0] a1, d1, lim1;

  // Waypoint memory: two banks, {z, y, x} per entry.
  logic [95:0]       wp_mem [twm_pkg::MEM_DEPTH];
  logic [95:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [95:0]       mem_wd;

  logic              bank;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count, idx_i, kept;
  logic [IDX_W-1:0]  rd_idx, app_idx;

  logic signed [31:0] cur_pos [3];
  logic signed [31:0] seg_start [3];
  logic signed [31:0] prev [3];
  logic [95:0]        w;
  logic [31:0]        cur_speed, pss, pst, now_r, moved;
  logic [31:0]        pt [3];
  logic               active, full_r, in_tick;

  // Planning registers
  logic [TOT_W-1:0] total;
  logic [31:0]      total_sat;
  logic [63:0]      s4, v02, y, y_full;
  logic [31:0]      f, vm, accd, decd, cr;
  logic [32:0]      accdec;

  // Segment length registers
  logic [30:0] e [3];
  logic        big;
  logic [63:0] acc;
  logic [31:0] len;
  logic [31:0] sl_abs [3];
  logic        sl_big;

  // Tick registers
  logic [31:0] ta, rem, tc, td, m2, v1, dvel, term, vfin, trav, trav_c, half;
  logic [34:0] disp;
  logic [31:0] dispq;
  logic [1:0]  axis;
  logic [31:0] mag [3];
  logic [33:0] qc;
  logic signed [35:0] ip_res;
  logic [63:0] ip_q;
  logic [31:0] t_el;

  // Shared multiplier
  logic        mul_go;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic [31:0] prod_q;

  // Shared divider, one quotient bit per cycle
  logic        div_go, dv_busy, dv_done;
  logic [63:0] div_num, dv_q;
  logic [32:0] div_den, dv_b, dv_r;
  logic [5:0]  dv_cnt;
  logic [33:0] dv_rs;

  // Shared square-root unit, one result bit per cycle
  logic        sq_go, sq_busy, sq_done;
  logic [63:0] sq_num, sq_n, sq_r, sq_bit, sq_trial;
  logic [4:0]  sq_cnt;

  assign in_cmd  = twm_pkg::cmd_t'(s_tuser);
  assign a1      = (accel_rate  != 32'd0) ? accel_rate  : 32'd1;
  assign d1      = (decel_rate  != 32'd0) ? decel_rate  : 32'd1;
  assign lim1    = (speed_limit != 32'd0) ? speed_limit : 32'd1;
  assign rd_idx  = head + idx_i[IDX_W-1:0];
  assign app_idx = head + count[IDX_W-1:0];
  assign prod_q  = twm_pkg::qmul(prod);
  assign t_el    = now_r - pst;
  assign total_sat = (total[TOT_W-1:32] != '0) ? 32'hFFFF_FFFF : total[31:0];
  assign y_full  = y + {32'd0, prod[63:32]};
  assign accdec  = {1'b0, accd} + {1'b0, decd};
  assign cr      = ({1'b0, total_sat} > accdec) ? 32'(({1'b0, total_sat} - accdec)) : 32'd0;
  assign dispq   = (disp[34:32] != 3'd0) ? 32'hFFFF_FFFF : disp[31:0];
  assign trav_c  = (dispq > moved) ? dispq - moved : 32'd0;
  assign half    = prod_q >> 1;

  // Axis differences for the segment length and the interpolation.
  always_comb begin
    logic signed [32:0] df;
    logic signed [32:0] dm;
    logic signed [31:0] pv;
    logic signed [31:0] qv;
    sl_big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      qv = w[32*k +: 32];
      pv = in_tick ? seg_start[k] : prev[k];
      df = {qv[31], qv} - {pv[31], pv};
      sl_abs[k] = df[32] ? 32'(-df) : df[31:0];
      if (sl_abs[k][31]) sl_big = 1'b1;
      dm = {qv[31], qv} - {seg_start[k][31], seg_start[k]};
      mag[k] = dm[32] ? 32'(-dm) : dm[31:0];
    end
  end

  // Interpolated coordinate on the current axis.
  always_comb begin
    logic signed [31:0] sv;
    logic signed [31:0] wv;
    ip_q = (len != 32'd0) ? dv_q : 64'd0;
    qc = (ip_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : ip_q[33:0];
    sv = seg_start[axis];
    wv = w[32*axis +: 32];
    if (wv < sv) ip_res = 36'(sv) - $signed({2'b00, qc});
    else ip_res = 36'(sv) + $signed({2'b00, qc});
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= twm_pkg::ONE_Q;
      accel_rate  <= twm_pkg::ONE_Q;
      decel_rate  <= twm_pkg::ONE_Q;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        twm_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data;
        twm_pkg::REG_ACCEL_RATE:  accel_rate  <= cfg_data;
        twm_pkg::REG_DECEL_RATE:  decel_rate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory
  always_ff @(posedge clk) begin
    if (mem_we) wp_mem[mem_wa] <= mem_wd;
    rd_data <= wp_mem[mem_ra];
  end

  // Multiplier
  always_ff @(posedge clk) begin
    if (mul_go) prod <= {32'd0, mul_x} * {32'd0, mul_y};
  end

  // Divider
  assign dv_rs = {dv_r, dv_q[63]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt  <= '0;
    end else begin
      dv_done <= 1'b0;
      if (div_go) begin
        dv_q    <= div_num;
        dv_b    <= div_den;
        dv_r    <= '0;
        dv_cnt  <= '0;
        dv_busy <= 1'b1;
      end else if (dv_busy) begin
        if (dv_rs >= {1'b0, dv_b}) begin
          dv_r <= 33'(dv_rs - {1'b0, dv_b});
          dv_q <= {dv_q[62:0], 1'b1};
        end else begin
          dv_r <= dv_rs[32:0];
          dv_q <= {dv_q[62:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 6'd1;
        if (dv_cnt == 6'd63) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  // Square root
  assign sq_trial = sq_r + sq_bit;
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
    end else begin
      sq_done <= 1'b0;
      if (sq_go) begin
        sq_n    <= sq_num;
        sq_r    <= '0;
        sq_bit  <= 64'd1 << 62;
        sq_cnt  <= '0;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_n >= sq_trial) begin
          sq_n <= sq_n - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
        if (sq_cnt == 5'd31) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= twm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Next state and unit controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_go     = 1'b0;
    mul_x      = '0;
    mul_y      = '0;
    div_go     = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_go      = 1'b0;
    sq_num     = '0;
    mem_we     = 1'b0;
    mem_wa     = {bank, head};
    mem_wd     = s_tdata[127:32];
    mem_ra     = {bank, head};
    unique case (state)
      twm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (in_cmd)
            twm_pkg::CMD_TICK: state_next = active ? twm_pkg::ST_TK_A : twm_pkg::ST_FIN;
            twm_pkg::CMD_REPLACE: begin
              mem_we     = 1'b1;
              mem_wa     = {bank, {IDX_W{1'b0}}};
              state_next = twm_pkg::ST_RP_RD;
            end
            twm_pkg::CMD_APPEND: begin
              if (count < CNT_W'(twm_pkg::MAX_WP)) begin
                mem_we = 1'b1;
                mem_wa = {bank, app_idx};
              end
              state_next = twm_pkg::ST_RP_RD;
            end
            default: state_next = twm_pkg::ST_FIN;
          endcase
        end
      end
      twm_pkg::ST_RP_RD: begin
        mem_ra = {bank, rd_idx};
        state_next = (idx_i == count) ? twm_pkg::ST_PK_M0 : twm_pkg::ST_RP_DAT;
      end
      twm_pkg::ST_RP_DAT: state_next = twm_pkg::ST_SL_DIFF;
      twm_pkg::ST_SL_DIFF: state_next = twm_pkg::ST_SL_M0;
      twm_pkg::ST_SL_M0: begin
        mul_go = 1'b1;
        mul_x  = {1'b0, e[0]};
        mul_y  = {1'b0, e[0]};
        state_next = twm_pkg::ST_SL_M1;
      end
      twm_pkg::ST_SL_M1: begin
        mul_go = 1'b1;
        mul_x  = {1'b0, e[1]};
        mul_y  = {1'b0, e[1]};
        state_next = twm_pkg::ST_SL_M2;
      end
      twm_pkg::ST_SL_M2: begin
        mul_go = 1'b1;
        mul_x  = {1'b0, e[2]};
        mul_y  = {1'b0, e[2]};
        state_next = twm_pkg::ST_SL_M3;
      end
      twm_pkg::ST_SL_M3: begin
        sq_go  = 1'b1;
        sq_num = acc + prod;
        state_next = twm_pkg::ST_SL_SQ;
      end
      twm_pkg::ST_SL_SQ: begin
        if (sq_done) state_next = in_tick ? twm_pkg::ST_WK_LEN : twm_pkg::ST_RP_LEN;
      end
      twm_pkg::ST_RP_LEN: begin
        if (len >= twm_pkg::EPS_RAW) begin
          mem_we = 1'b1;
          mem_wa = {~bank, kept[IDX_W-1:0]};
          mem_wd = w;
        end
        state_next = twm_pkg::ST_RP_RD;
      end
      twm_pkg::ST_PK_M0: begin
        mul_go = 1'b1;
        mul_x  = a1;
        mul_y  = total_sat;
        state_next = twm_pkg::ST_PK_M1;
      end
      twm_pkg::ST_PK_M1: begin
        mul_go = 1'b1;
        mul_x  = pss;
        mul_y  = pss;
        state_next = twm_pkg::ST_PK_M2;
      end
      twm_pkg::ST_PK_M2: begin
        div_go  = 1'b1;
        div_num = {d1, 32'd0};
        div_den = {1'b0, a1} + {1'b0, d1};
        state_next = twm_pkg::ST_PK_DF;
      end
      twm_pkg::ST_PK_DF: if (dv_done) state_next = twm_pkg::ST_PK_M3;
      twm_pkg::ST_PK_M3: begin
        mul_go = 1'b1;
        mul_x  = s4[63:32];
        mul_y  = f;
        state_next = twm_pkg::ST_PK_M4;
      end
      twm_pkg::ST_PK_M4: begin
        mul_go = 1'b1;
        mul_x  = s4[31:0];
        mul_y  = f;
        state_next = twm_pkg::ST_PK_Y;
      end
      twm_pkg::ST_PK_Y: begin
        if (y_full[63:62] != 2'b00) begin
          state_next = twm_pkg::ST_PK_VM;
        end else begin
          sq_go  = 1'b1;
          sq_num = {y_full[61:0], 2'b00};
          state_next = twm_pkg::ST_PK_SQ;
        end
      end
      twm_pkg::ST_PK_SQ: if (sq_done) state_next = twm_pkg::ST_PK_VM;
      twm_pkg::ST_PK_VM: begin
        div_go = 1'b1;
        if (pss > vm) begin
          div_num = twm_pkg::frac_shl(pss);
          div_den = {1'b0, d1};
          state_next = twm_pkg::ST_PK_D2;
        end else begin
          div_num = twm_pkg::frac_shl(vm - pss);
          div_den = {1'b0, a1};
          mul_go  = 1'b1;
          mul_x   = vm;
          mul_y   = vm;
          state_next = twm_pkg::ST_PK_D0;
        end
      end
      twm_pkg::ST_PK_D0: begin
        if (dv_done) begin
          div_go  = 1'b1;
          div_num = prod - v02;
          div_den = {a1, 1'b0};
          state_next = twm_pkg::ST_PK_DA;
        end
      end
      twm_pkg::ST_PK_DA: begin
        if (dv_done) begin
          div_go  = 1'b1;
          div_num = prod;
          div_den = {d1, 1'b0};
          state_next = twm_pkg::ST_PK_DD;
        end
      end
      twm_pkg::ST_PK_DD: if (dv_done) state_next = twm_pkg::ST_PK_CR;
      twm_pkg::ST_PK_CR: begin
        div_go = 1'b1;
        if (vm != 32'd0) begin
          div_num = twm_pkg::frac_shl(cr);
          div_den = {1'b0, vm};
          state_next = twm_pkg::ST_PK_D1;
        end else begin
          div_num = twm_pkg::frac_shl(vm);
          div_den = {1'b0, d1};
          state_next = twm_pkg::ST_PK_D2;
        end
      end
      twm_pkg::ST_PK_D1: begin
        if (dv_done) begin
          div_go  = 1'b1;
          div_num = twm_pkg::frac_shl(vm);
          div_den = {1'b0, d1};
          state_next = twm_pkg::ST_PK_D2;
        end
      end
      twm_pkg::ST_PK_D2: if (dv_done) state_next = twm_pkg::ST_FIN;
      twm_pkg::ST_TK_A: state_next = twm_pkg::ST_TK_B;
      twm_pkg::ST_TK_B: begin
        mul_go = 1'b1;
        mul_x  = pss;
        mul_y  = ta;
        state_next = twm_pkg::ST_TK_C;
      end
      twm_pkg::ST_TK_C: begin
        mul_go = 1'b1;
        mul_x  = a1;
        mul_y  = ta;
        state_next = twm_pkg::ST_TK_D;
      end
      twm_pkg::ST_TK_D: state_next = twm_pkg::ST_TK_E;
      twm_pkg::ST_TK_E: begin
        mul_go = 1'b1;
        mul_x  = m2;
        mul_y  = ta;
        state_next = twm_pkg::ST_TK_F;
      end
      twm_pkg::ST_TK_F: begin
        mul_go = 1'b1;
        mul_x  = v1;
        mul_y  = tc;
        state_next = twm_pkg::ST_TK_G;
      end
      twm_pkg::ST_TK_G: begin
        mul_go = 1'b1;
        mul_x  = d1;
        mul_y  = td;
        state_next = twm_pkg::ST_TK_H;
      end
      twm_pkg::ST_TK_H: begin
        mul_go = 1'b1;
        mul_x  = v1;
        mul_y  = td;
        state_next = twm_pkg::ST_TK_I;
      end
      twm_pkg::ST_TK_I: begin
        mul_go = 1'b1;
        mul_x  = dvel;
        mul_y  = td;
        state_next = twm_pkg::ST_TK_J;
      end
      twm_pkg::ST_TK_J: state_next = twm_pkg::ST_WK_RD;
      twm_pkg::ST_WK_RD: begin
        mem_ra = {bank, head};
        state_next = (count == '0) ? twm_pkg::ST_TK_END : twm_pkg::ST_WK_DAT;
      end
      twm_pkg::ST_WK_DAT: state_next = twm_pkg::ST_SL_DIFF;
      twm_pkg::ST_WK_LEN: begin
        if (count == CNT_W'(1) || trav_c < len) state_next = twm_pkg::ST_IP_MUL;
        else state_next = twm_pkg::ST_WK_RD;
      end
      twm_pkg::ST_IP_MUL: begin
        mul_go = 1'b1;
        mul_x  = trav;
        mul_y  = mag[axis];
        state_next = twm_pkg::ST_IP_DIV;
      end
      twm_pkg::ST_IP_DIV: begin
        if (len != 32'd0) begin
          div_go  = 1'b1;
          div_num = prod;
          div_den = {1'b0, len};
          state_next = twm_pkg::ST_IP_WAIT;
        end else begin
          state_next = twm_pkg::ST_IP_WR;
        end
      end
      twm_pkg::ST_IP_WAIT: if (dv_done) state_next = twm_pkg::ST_IP_WR;
      twm_pkg::ST_IP_WR: state_next = (axis == 2'd2) ? twm_pkg::ST_TK_END : twm_pkg::ST_IP_MUL;
      twm_pkg::ST_TK_END: state_next = twm_pkg::ST_FIN;
      twm_pkg::ST_FIN: if (!m_tvalid || m_tready) state_next = twm_pkg::ST_IDLE;
      default: state_next = twm_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      head      <= '0;
      count     <= '0;
      active    <= 1'b0;
      full_r    <= 1'b0;
      in_tick   <= 1'b0;
      cur_speed <= '0;
      pss       <= '0;
      pst       <= '0;
      moved     <= '0;
      for (int k = 0; k < 3; k++) begin
        cur_pos[k]   <= '0;
        seg_start[k] <= '0;
        pt[k]        <= '0;
      end
    end else begin
      unique case (state)
        twm_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            now_r   <= s_tdata[31:0];
            full_r  <= 1'b0;
            in_tick <= (in_cmd == twm_pkg::CMD_TICK);
            if (in_cmd == twm_pkg::CMD_REPLACE || in_cmd == twm_pkg::CMD_APPEND) begin
              if (in_cmd == twm_pkg::CMD_REPLACE) begin
                head  <= '0;
                count <= CNT_W'(1);
              end else if (count < CNT_W'(twm_pkg::MAX_WP)) begin
                count <= count + CNT_W'(1);
              end else begin
                full_r <= 1'b1;
              end
              pss   <= cur_speed;
              pst   <= s_tdata[31:0];
              idx_i <= '0;
              kept  <= '0;
              total <= '0;
              for (int k = 0; k < 3; k++) begin
                seg_start[k] <= cur_pos[k];
                prev[k]      <= cur_pos[k];
              end
            end
          end
        end
        twm_pkg::ST_RP_RD: begin
          if (idx_i == count) begin
            bank  <= ~bank;
            head  <= '0;
            count <= kept;
          end
        end
        twm_pkg::ST_RP_DAT, twm_pkg::ST_WK_DAT: w <= rd_data;
        twm_pkg::ST_SL_DIFF: begin
          big <= sl_big;
          for (int k = 0; k < 3; k++) begin
            e[k] <= sl_big ? sl_abs[k][31:1] : sl_abs[k][30:0];
          end
        end
        twm_pkg::ST_SL_M1: acc <= prod;
        twm_pkg::ST_SL_M2: acc <= acc + prod;
        twm_pkg::ST_SL_SQ: begin
          if (sq_done) len <= big ? twm_pkg::sat32({sq_r[62:0], 1'b0}) : sq_r[31:0];
        end
        twm_pkg::ST_RP_LEN: begin
          if (len >= twm_pkg::EPS_RAW) begin
            total <= total + TOT_W'(len);
            kept  <= kept + CNT_W'(1);
            for (int k = 0; k < 3; k++) prev[k] <= w[32*k +: 32];
          end
          idx_i <= idx_i + CNT_W'(1);
        end
        twm_pkg::ST_PK_M1: s4 <= prod >> 1;
        twm_pkg::ST_PK_M2: begin
          s4  <= s4 + (prod >> 2);
          v02 <= prod;
        end
        twm_pkg::ST_PK_DF: if (dv_done) f <= dv_q[31:0];
        twm_pkg::ST_PK_Y: begin
          y <= y_full;
          if (y_full[63:62] != 2'b00) vm <= lim1;
        end
        twm_pkg::ST_PK_M4: y <= prod;
        twm_pkg::ST_PK_SQ: if (sq_done) vm <= twm_pkg::min32(sq_r[31:0], lim1);
        twm_pkg::ST_PK_VM: begin
          if (pss > vm) begin
            pt[0] <= '0;
            pt[1] <= '0;
          end
        end
        twm_pkg::ST_PK_D0: if (dv_done) pt[0] <= twm_pkg::sat32(dv_q);
        twm_pkg::ST_PK_DA: if (dv_done) accd <= twm_pkg::sat32(dv_q);
        twm_pkg::ST_PK_DD: if (dv_done) decd <= twm_pkg::sat32(dv_q);
        twm_pkg::ST_PK_CR: if (vm == 32'd0) pt[1] <= '0;
        twm_pkg::ST_PK_D1: if (dv_done) pt[1] <= twm_pkg::sat32(dv_q);
        twm_pkg::ST_PK_D2: begin
          if (dv_done) begin
            pt[2]  <= twm_pkg::sat32(dv_q);
            moved  <= '0;
            active <= 1'b1;
          end
        end
        twm_pkg::ST_TK_A: begin
          ta  <= twm_pkg::min32(t_el, pt[0]);
          rem <= t_el - twm_pkg::min32(t_el, pt[0]);
        end
        twm_pkg::ST_TK_C: disp <= 35'(prod_q);
        twm_pkg::ST_TK_D: m2 <= prod_q;
        twm_pkg::ST_TK_E: begin
          v1  <= twm_pkg::sat32({32'd0, pss} + {32'd0, m2});
          tc  <= twm_pkg::min32(rem, pt[1]);
          rem <= rem - twm_pkg::min32(rem, pt[1]);
        end
        twm_pkg::ST_TK_F: begin
          disp <= disp + 35'(prod_q >> 1);
          td   <= twm_pkg::min32(rem, pt[2]);
        end
        twm_pkg::ST_TK_G: disp <= disp + 35'(prod_q);
        twm_pkg::ST_TK_H: dvel <= prod_q;
        twm_pkg::ST_TK_I: term <= prod_q;
        twm_pkg::ST_TK_J: begin
          if (term > half) disp <= disp + 35'(term - half);
          // Once every phase has run out the profile is at rest.
          if (ta == pt[0] && tc == pt[1] && td == pt[2]) vfin <= '0;
          else vfin <= (v1 > dvel) ? v1 - dvel : 32'd0;
        end
        twm_pkg::ST_WK_LEN: begin
          trav <= trav_c;
          axis <= 2'd0;
          if (!(count == CNT_W'(1) || trav_c < len)) begin
            // Waypoint passed: it becomes the start of the next segment.
            for (int k = 0; k < 3; k++) begin
              cur_pos[k]   <= w[32*k +: 32];
              seg_start[k] <= w[32*k +: 32];
            end
            head  <= head + IDX_W'(1);
            count <= count - CNT_W'(1);
            moved <= twm_pkg::sat32({32'd0, moved} + {32'd0, len});
          end
        end
        twm_pkg::ST_IP_WR: begin
          cur_pos[axis] <= twm_pkg::clamp_s32(ip_res);
          axis <= axis + 2'd1;
        end
        twm_pkg::ST_TK_END: begin
          cur_speed <= vfin;
          if (vfin == 32'd0 && ta == pt[0]) active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == twm_pkg::ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, full_r, count, active, cur_speed,
                   cur_pos[2], cur_pos[1], cur_pos[0]};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
